// ===== src/assert_macros.svh =====
// assertion macros used by the rtl core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/gcc_pkg.sv =====
// shared types and constants of the graph connectivity checker
package gcc_pkg;

  localparam int VERTEX_W = 6;
  localparam int COUNT_W  = 7;

  // request codes
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_EVAL = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [VERTEX_W-1:0] vertex_a;
    logic [VERTEX_W-1:0] vertex_b;
  } gcc_req_t;

  typedef struct packed {
    logic               connected;
    logic [COUNT_W-1:0] visited_count;
    logic               bad_edge_seen;
  } gcc_rsp_t;

endpackage

// ===== src/gcc_if.sv =====
// valid/ready channel interfaces for requests and results
interface gcc_req_if import gcc_pkg::*; ();
  logic     valid;
  logic     ready;
  gcc_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gcc_rsp_if import gcc_pkg::*; ();
  logic     valid;
  logic     ready;
  gcc_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== src/graph_connectivity_check_core.sv =====
// Depth-first connectivity checker of one undirected graph. Add transactions store an edge
// in a MAX_VERTICES x MAX_VERTICES adjacency memory; because the memory has one write port,
// each accepted edge makes two row writes, one per direction (the second in S_EDGE2);
// an out-of-range edge is rejected and only sets the bad-edge flag. An evaluate walks the
// graph from vertex 0 with a stack memory and a single neighbor-test step that checks one
// candidate per cycle: each popped vertex passes S_POP and S_ROW, then S_SCAN tests every
// candidate below the effective vertex count n. S_DONE (entered at once when n is 0)
// registers the result when the result register is free. The block takes no request while
// an edge write or a walk is in progress. Per-row valid bits clear the graph in the cycle
// the result is loaded, so no clearing pass is needed after reset or between graphs.
`include "assert_macros.svh"

module graph_connectivity_check_core
  import gcc_pkg::*;
#(
  parameter int MAX_VERTICES = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [COUNT_W-1:0] cfg_wr_data,
  gcc_req_if.sink            in_ch,
  gcc_rsp_if.source          out_ch
);

  localparam int SW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int CW = (NW > COUNT_W) ? NW : COUNT_W;
  localparam logic [CW-1:0] MAX_N = CW'(MAX_VERTICES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EDGE2 = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]              state_r, state_nxt;
  logic [COUNT_W-1:0]      vcount_r;
  logic [CW-1:0]           n_r, n_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] row_valid_r, row_valid_nxt;
  logic [CW-1:0]           reached_r, reached_nxt;
  logic [NW-1:0]           sp_r, sp_nxt;
  logic [CW-1:0]           w_r, w_nxt;
  logic [SW-1:0]           e2_row_r, e2_row_nxt;
  logic [SW-1:0]           e2_bit_r, e2_bit_nxt;
  logic                    any_edge_r, any_edge_nxt;
  logic                    bad_r, bad_nxt;
  logic                    out_valid_r, out_valid_nxt;
  gcc_rsp_t                out_data_r, out_data_nxt;
  logic                    out_load;

  logic [SW-1:0]           v_r;
  logic [MAX_VERTICES-1:0] row_rd_r;
  logic                    row_vld_r;

  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [SW-1:0]           stack_mem [MAX_VERTICES];

  logic                    adj_we;
  logic [SW-1:0]           adj_wa;
  logic [SW-1:0]           adj_wbit;
  logic                    stk_we;
  logic [SW-1:0]           stk_wa;
  logic [SW-1:0]           stk_wd;

  logic [CW-1:0]           eff_n;
  logic [CW-1:0]           a_ext;
  logic [CW-1:0]           b_ext;
  logic                    edge_ok;
  logic                    in_fire;
  logic [NW-1:0]           sp_dec;
  logic [SW-1:0]           scan_idx;
  logic                    scan_hit;
  logic                    scan_last;
  logic                    out_free;
  logic                    conn;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  assign eff_n     = (CW'(vcount_r) < MAX_N) ? CW'(vcount_r) : MAX_N;
  assign a_ext     = CW'(in_ch.data.vertex_a);
  assign b_ext     = CW'(in_ch.data.vertex_b);
  assign edge_ok   = (a_ext < eff_n) && (b_ext < eff_n);
  assign sp_dec    = sp_r - NW'(1);
  assign scan_idx  = w_r[SW-1:0];
  // a row never written since the last clear reads as empty
  assign scan_hit  = row_vld_r && row_rd_r[scan_idx] && !visited_r[scan_idx];
  assign scan_last = ((w_r + CW'(1)) == n_r);
  assign out_free  = !out_valid_r || out_ch.ready;
  assign conn      = any_edge_r && (n_r != '0) && (reached_r == n_r);

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    visited_nxt   = visited_r;
    row_valid_nxt = row_valid_r;
    reached_nxt   = reached_r;
    sp_nxt        = sp_r;
    w_nxt         = w_r;
    e2_row_nxt    = e2_row_r;
    e2_bit_nxt    = e2_bit_r;
    any_edge_nxt  = any_edge_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_load      = 1'b0;
    out_data_nxt  = out_data_r;
    adj_we        = 1'b0;
    adj_wa        = '0;
    adj_wbit      = '0;
    stk_we        = 1'b0;
    stk_wa        = '0;
    stk_wd        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.data.req_type)
            REQ_ADD: begin
              if (edge_ok) begin
                adj_we       = 1'b1;
                adj_wa       = SW'(in_ch.data.vertex_a);
                adj_wbit     = SW'(in_ch.data.vertex_b);
                e2_row_nxt   = SW'(in_ch.data.vertex_b);
                e2_bit_nxt   = SW'(in_ch.data.vertex_a);
                any_edge_nxt = 1'b1;
                state_nxt    = S_EDGE2;
              end else begin
                bad_nxt = 1'b1;
              end
            end
            REQ_EVAL: begin
              n_nxt = eff_n;
              if (eff_n == '0) begin
                state_nxt = S_DONE;
              end else begin
                visited_nxt[0] = 1'b1;
                reached_nxt    = CW'(1);
                stk_we         = 1'b1;
                stk_wa         = '0;
                stk_wd         = '0;
                sp_nxt         = NW'(1);
                state_nxt      = S_POP;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EDGE2: begin
        adj_we    = 1'b1;
        adj_wa    = e2_row_r;
        adj_wbit  = e2_bit_r;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        if (sp_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          sp_nxt    = sp_dec;
          state_nxt = S_ROW;
        end
      end
      S_ROW: begin
        w_nxt     = '0;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        if (scan_hit) begin
          visited_nxt[scan_idx] = 1'b1;
          reached_nxt           = reached_r + CW'(1);
          stk_we                = 1'b1;
          stk_wa                = sp_r[SW-1:0];
          stk_wd                = scan_idx;
          sp_nxt                = sp_r + NW'(1);
        end
        if (scan_last) begin
          state_nxt = S_POP;
        end else begin
          w_nxt = w_r + CW'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_valid_nxt              = 1'b1;
          out_data_nxt.connected     = conn;
          out_data_nxt.visited_count = reached_r[COUNT_W-1:0];
          out_data_nxt.bad_edge_seen = bad_r;
          // graph cleared for the next one
          row_valid_nxt              = '0;
          visited_nxt                = '0;
          reached_nxt                = '0;
          sp_nxt                     = '0;
          any_edge_nxt               = 1'b0;
          bad_nxt                    = 1'b0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adj_we) begin
      row_valid_nxt[adj_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vcount_r    <= COUNT_W'(1);
      visited_r   <= '0;
      row_valid_r <= '0;
      reached_r   <= '0;
      sp_r        <= '0;
      any_edge_r  <= 1'b0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      row_valid_r <= row_valid_nxt;
      reached_r   <= reached_nxt;
      sp_r        <= sp_nxt;
      any_edge_r  <= any_edge_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        vcount_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    w_r      <= w_nxt;
    e2_row_r <= e2_row_nxt;
    e2_bit_r <= e2_bit_nxt;
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  // adjacency memory: a row that is not yet valid is rewritten whole as a one-hot row
  always_ff @(posedge clk) begin
    if (adj_we) begin
      for (int i = 0; i < MAX_VERTICES; i++) begin
        if (!row_valid_r[adj_wa] || (adj_wbit == SW'(i))) begin
          adj_mem[adj_wa][i] <= (adj_wbit == SW'(i));
        end
      end
    end
    if (state_r == S_ROW) begin
      row_rd_r  <= adj_mem[v_r];
      row_vld_r <= row_valid_r[v_r];
    end
  end

  // walk stack memory
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_wa] <= stk_wd;
    end
    if (state_r == S_POP) begin
      v_r <= stack_mem[sp_dec[SW-1:0]];
    end
  end

  `ASSERT_IMPL(a_count_matches_map, 1'b1,
    reached_r == CW'($countones(visited_r)), "reached count differs from visited map")
  `ASSERT_IMPL(a_stack_within_reached, 1'b1,
    CW'(sp_r) <= reached_r, "stack deeper than reached vertices")
  `ASSERT_IMPL(a_result_from_done, out_valid_r && !$past(out_valid_r),
    $past(state_r) == S_DONE, "result loaded outside done state")

endmodule
